// ===== design/rs15_pkg.sv =====
// Package for the RS(15,3) GF(16) encoder: codeword type, field constants,
// root list and the GF(16) multiply function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rs15_pkg;

    localparam int CW_LEN  = 15;
    localparam int N_ROOTS = 12;
    localparam int SYM_W   = 4;
    localparam int IDX_W   = 4;
    localparam int ID_W    = 12;

    localparam logic [SYM_W:0] GF_POLY = 5'h19;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'(CW_LEN - 1);

    localparam logic [SYM_W-1:0] ROOTS [N_ROOTS] = '{
        4'd2, 4'd4, 4'd8, 4'd9, 4'd11, 4'd15, 4'd7, 4'd14, 4'd5, 4'd10, 4'd13, 4'd3
    };

    typedef logic [CW_LEN-1:0][SYM_W-1:0] t_cw;

    function automatic logic [SYM_W-1:0] gf16_mul(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] b);
        logic [SYM_W:0]   x;
        logic [SYM_W-1:0] acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = {x[SYM_W-1:0], 1'b0};
            if (x[SYM_W]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== design/rs15_pipe.sv =====
// Twelve-stage pipeline that multiplies the message polynomial by one
// factor (x + c) per stage. Depends on rs15_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rs15_pipe (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  rs15_pkg::t_cw    i_cw,
    output logic             o_valid,
    input  wire              i_ready,
    output rs15_pkg::t_cw    o_cw
);

    logic [rs15_pkg::N_ROOTS-1:0] r_v;
    rs15_pkg::t_cw                r_cw [rs15_pkg::N_ROOTS];
    rs15_pkg::t_cw                n_cw [rs15_pkg::N_ROOTS];
    logic [rs15_pkg::N_ROOTS:0]   w_rdy;

    assign w_rdy[rs15_pkg::N_ROOTS] = i_ready;

    genvar k;
    generate
        for (k = 0; k < rs15_pkg::N_ROOTS; k++) begin : g_stage
            rs15_pkg::t_cw w_in;
            logic          w_vin;

            if (k == 0) begin : g_first
                assign w_in  = i_cw;
                assign w_vin = i_valid;
            end else begin : g_next
                assign w_in  = r_cw[k-1];
                assign w_vin = r_v[k-1];
            end

            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

            always_comb begin
                n_cw[k][0] = rs15_pkg::gf16_mul(w_in[0], rs15_pkg::ROOTS[k]);
                for (int j = 1; j < rs15_pkg::CW_LEN; j++) begin
                    n_cw[k][j] = w_in[j-1] ^ rs15_pkg::gf16_mul(w_in[j], rs15_pkg::ROOTS[k]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_v[k] <= w_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_vin) begin
                    r_cw[k] <= n_cw[k];
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[rs15_pkg::N_ROOTS-1];
    assign o_cw    = r_cw[rs15_pkg::N_ROOTS-1];

endmodule

`default_nettype wire

// ===== design/rs15_3_gf16_encoder_top.sv =====
// Top level of the RS(15,3) GF(16) encoder: the root pipeline followed by a
// codeword register that sends one symbol per transaction. Depends on rs15_pkg
// and rs15_pipe.
//
// Channel   Direction  Payload
// s_axis    in         tdata[11:0] id_code, tdata[15:12] unused
// m_axis    out        tdata[3:0] symbol, tdata[7:4] symbol_index, tlast last
//
// A codeword leaves the twelve-stage root pipeline into the codeword register
// and then takes 15 output transactions, one per cycle while m_axis is ready.
// The serializer limits the sustained rate to one identifier per codeword;
// up to twelve further identifiers are accepted into the pipeline meanwhile.
// Reset clears all valid bits. A stall on m_axis backs up through the
// pipeline stage by stage without losing or repeating a transaction.
`timescale 1ns / 1ps
`default_nettype none

module rs15_3_gf16_encoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // [11:0] id_code, [15:12] unused
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] symbol, [7:4] symbol_index
    output logic        o_m_axis_tlast
);

    rs15_pkg::t_cw                  w_in_cw;
    rs15_pkg::t_cw                  w_pipe_cw;
    logic                           w_pipe_valid;
    logic                           w_load_ok;
    logic                           w_out_fire;
    logic                           w_is_last;

    rs15_pkg::t_cw                  r_cw;
    logic [rs15_pkg::IDX_W-1:0]     r_idx;
    logic                           r_full;

    always_comb begin
        w_in_cw    = '0;
        w_in_cw[0] = i_s_axis_tdata[11:8];
        w_in_cw[1] = i_s_axis_tdata[7:4];
        w_in_cw[2] = i_s_axis_tdata[3:0];
    end

    rs15_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cw    (w_in_cw),
        .o_valid (w_pipe_valid),
        .i_ready (w_load_ok),
        .o_cw    (w_pipe_cw)
    );

    assign w_is_last  = (r_idx == rs15_pkg::LAST_IDX);
    assign w_out_fire = r_full && i_m_axis_tready;
    assign w_load_ok  = !r_full || (i_m_axis_tready && w_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (w_load_ok && w_pipe_valid) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (w_out_fire) begin
            if (w_is_last) begin
                r_full <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_ok && w_pipe_valid) begin
            r_cw <= w_pipe_cw;
        end
    end

    assign o_m_axis_tvalid = r_full;
    assign o_m_axis_tdata  = {r_idx, r_cw[r_idx]};
    assign o_m_axis_tlast  = w_is_last;

endmodule

`default_nettype wire

// ===== test/rs15_codeword_check_pkg.sv =====
// Codeword checker for the RS(15,3) GF(16) encoder bench: predicts the fifteen
// symbols of each identifier and compares them in order. Depends on rs15_pkg.
`timescale 1ns / 1ps

package rs15_codeword_check_pkg;

    localparam int SYM_W = rs15_pkg::SYM_W;
    localparam int CW_N  = rs15_pkg::CW_LEN;
    localparam logic [SYM_W-1:0] CODE_ROOTS [12] = '{
        4'd2, 4'd4, 4'd8, 4'd9, 4'd11, 4'd15, 4'd7, 4'd14, 4'd5, 4'd10, 4'd13, 4'd3
    };
    localparam logic [SYM_W-1:0] REDUCE_LOW = 4'h9;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SYM_W-1:0]           symbol;
        logic [rs15_pkg::IDX_W-1:0] index;
        logic                       last;
    } t_coded_symbol;

    class codeword_checker;
        t_coded_symbol waiting_symbols[$];
        int codewords_noted;
        int symbols_checked;
        int mismatch_count;

        function logic [SYM_W-1:0] gf_times(logic [SYM_W-1:0] a,
                                            logic [SYM_W-1:0] b);
            logic [SYM_W-1:0] prod;
            logic [SYM_W-1:0] mult;
            prod = '0;
            mult = a;
            for (int k = 0; k < SYM_W; k++) begin
                if (b[k]) begin
                    prod = prod ^ mult;
                end
                mult = mult[SYM_W-1] ? ({mult[SYM_W-2:0], 1'b0} ^ REDUCE_LOW)
                                     : {mult[SYM_W-2:0], 1'b0};
            end
            return prod;
        endfunction

        function void note_id(logic [11:0] id);
            logic [SYM_W-1:0] cw [CW_N];
            t_coded_symbol    sym;
            foreach (cw[j]) begin
                cw[j] = '0;
            end
            cw[0] = id[11:8];
            cw[1] = id[7:4];
            cw[2] = id[3:0];
            foreach (CODE_ROOTS[r]) begin
                for (int j = CW_N - 1; j > 0; j--) begin
                    cw[j] = cw[j-1] ^ gf_times(cw[j], CODE_ROOTS[r]);
                end
                cw[0] = gf_times(cw[0], CODE_ROOTS[r]);
            end
            for (int j = 0; j < CW_N; j++) begin
                sym.symbol = cw[j];
                sym.index  = 4'(j);
                sym.last   = (j == CW_N - 1);
                waiting_symbols.push_back(sym);
            end
            codewords_noted++;
        endfunction

        function void check_symbol(logic [SYM_W-1:0] symbol, logic [3:0] index,
                                   logic last);
            t_coded_symbol want;
            symbols_checked++;
            if (waiting_symbols.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected symbol %h at index %0d, last %b: nothing pending.",
                             symbol, index, last);
                end
                return;
            end
            want = waiting_symbols.pop_front();
            if (want.symbol !== symbol || want.index !== index || want.last !== last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Symbol error: expected %h idx %0d last %b, got %h idx %0d last %b.",
                             want.symbol, want.index, want.last, symbol, index, last);
                end
            end
        endfunction

        function int pending();
            return waiting_symbols.size();
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level bench for rs15_3_gf16_encoder_top: drives identifiers, collects
// codeword symbols and scores them. Depends on rs15_pkg and rs15_codeword_check_pkg.
`timescale 1ns / 1ps

module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = 16'h0000;
    logic        m_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [7:0]  o_m_axis_tdata;
    wire         o_m_axis_tlast;

    int tx_gap_max = 5;
    int rx_stall_max = 5;
    int rx_hold_req = 0;

    rs15_codeword_check_pkg::codeword_checker board = new();

    rs15_3_gf16_encoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic send_id(input logic [11:0] id);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, id};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_id(id);
    endtask

    task automatic send_random_ids(input int count);
        for (int n = 0; n < count; n++) begin
            send_id(12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : rx_side
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                stall = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            board.check_symbol(o_m_axis_tdata[3:0], o_m_axis_tdata[7:4], o_m_axis_tlast);
        end
    end

    initial begin : tx_side
        logic [11:0] corner_ids [10];
        corner_ids = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hF00,
                       12'h0F0, 12'h00F, 12'h800, 12'h7FF, 12'h123};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_ids[k]) begin
            send_id(corner_ids[k]);
        end
        for (int b = 0; b < 12; b++) begin
            send_id(12'(1 << b));
        end

        tx_gap_max = 0;
        rx_stall_max = 0;
        send_random_ids(30);

        tx_gap_max = 5;
        rx_stall_max = 5;
        send_random_ids(23);

        tx_gap_max = 0;
        rx_hold_req = 400;
        send_random_ids(20);
        s_tvalid <= 1'b0;
        wait_drained();

        tx_gap_max = 3;
        rx_stall_max = 2;
        send_random_ids(15);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Encoded %0d identifiers (corners, walking ones, random), %0d symbols checked.",
                 board.codewords_noted, board.symbols_checked);
        $display("Idle gaps, back-to-back traffic and a long output hold: %0d errors, %0d pending.",
                 board.mismatch_count, board.pending());
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("Timed out with %0d symbols pending.", board.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
